/* sv/hsrc_pkg.sv */
// ============================================================================
// Host string classifier package
// Shared item types, scan state and character constants for the host
// string reserved-range classifier.
// ============================================================================
`default_nettype none

package hsrc_pkg;

    // Input item: one byte of the host string.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_host;
    } hsrc_in_t;

    // Result item: three classification flags.
    typedef struct packed {
        logic reserved;
        logic dotted_quad;
        logic valid_host;
    } hsrc_out_t;

    // Control from the top level to the scanner.
    typedef struct packed {
        logic step;     // the held item is consumed this cycle
        logic restart;  // the held item ends the host (last or empty)
    } hsrc_ctl_t;

    // Running parse state of one host string.
    typedef struct packed {
        logic [3:0]      char_count;
        logic [7:0]      held_char;
        logic            quad_ok;
        logic [1:0]      dot_count;
        logic [7:0]      group_value;
        logic            group_has_digit;
        logic [2:0][7:0] octet_store;
        logic            localhost_match;
        logic            zero_quad_match;
        logic            colon_seen;
        logic            open_bracket;
        logic            percent_seen;
        logic [3:0]      norm_count;
        logic [7:0][7:0] norm_head;
    } hsrc_state_t;

    localparam hsrc_state_t HSRC_STATE_RST = '{
        char_count:      4'd0,
        held_char:       8'd0,
        quad_ok:         1'b1,
        dot_count:       2'd0,
        group_value:     8'd0,
        group_has_digit: 1'b0,
        octet_store:     '0,
        localhost_match: 1'b1,
        zero_quad_match: 1'b1,
        colon_seen:      1'b0,
        open_bracket:    1'b0,
        percent_seen:    1'b0,
        norm_count:      4'd0,
        norm_head:       '0
    };

    // Character codes.
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_2       = 8'h32;
    localparam logic [7:0] CH_8       = 8'h38;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Text lengths used in the exact-match tests.
    localparam logic [3:0] LH_LEN = 4'd9;
    localparam logic [3:0] ZQ_LEN = 4'd7;
    localparam logic [3:0] NORM_HEAD_LEN = 4'd8;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Expected character of "localhost" at a position below nine.
    function automatic logic [7:0] lh_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h6C;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h63;
            4'd3:    c = 8'h61;
            4'd4:    c = 8'h6C;
            4'd5:    c = 8'h68;
            4'd6:    c = 8'h6F;
            4'd7:    c = 8'h73;
            4'd8:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected character of "0.0.0.0": digits at even places, dots between.
    function automatic logic [7:0] zq_char(input logic [3:0] pos);
        return pos[0] ? CH_DOT : CH_0;
    endfunction

    // The documentation prefix "2001:db8".
    localparam logic [7:0][7:0] DOC_PREFIX = {
        8'h38, 8'h62, 8'h64, 8'h3A, 8'h31, 8'h30, 8'h30, 8'h32
    };

endpackage

`default_nettype wire

/* sv/host_string_reserved_classifier.sv */
// A result passes through the input register and then the result register before it appears on m_.
// Throughput: one item per cycle, set by the single-character scan stage.
// An item that ends a host is held only while the result register is full and unread.
// Reset (aresetn low, synchronous) empties both registers and restores the
// parse state to the start of a new host.
// ============================================================================
// Host string reserved-range classifier
// Input register, one-character scan and classification, result register.
// ============================================================================
`default_nettype none

module host_string_reserved_classifier (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire hsrc_pkg::hsrc_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hsrc_pkg::hsrc_out_t      m_data
);
    import hsrc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    hsrc_in_t    in_item_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    hsrc_out_t   m_data_reg;
    logic        emits;
    logic        advance;
    hsrc_ctl_t   ctl;
    hsrc_state_t state_upd;
    hsrc_out_t   result;

    // The held item moves on unless it needs the result register and that is full.
    assign emits   = in_item_reg.last || in_item_reg.empty_host;
    assign advance = in_valid_reg && (!emits || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ctl.step    = advance;
    assign ctl.restart = emits;

    hsrc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .item      (in_item_reg),
        .state_upd (state_upd)
    );

    hsrc_classify u_classify (
        .st         (state_upd),
        .empty_host (in_item_reg.empty_host),
        .result     (result)
    );

    // Input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && emits) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emits) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // The input side stalls only behind a full, unread result register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && emits && m_valid_reg && !m_ready))
        else $error("input stalled without a full result register");

    // A host that is not valid is always reported as reserved.
    a_invalid_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_host) |-> m_data.reserved)
        else $error("invalid host not flagged reserved");

    // An empty host gives the fixed empty result on the next cycle.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.empty_host) |=>
            (m_valid && m_data.reserved && !m_data.dotted_quad && !m_data.valid_host))
        else $error("empty host result wrong");

    // A final item that moves on always loads a result.
    a_final_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emits) |=> m_valid)
        else $error("final item produced no result");
`endif

endmodule

`default_nettype wire

/* sv/hsrc_scan.sv */
// ============================================================================
// Host string scanner
// Holds the parse state of the current host and folds in one character per
// step; the post-character state feeds the classifier.
// ============================================================================
`default_nettype none

module hsrc_scan (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hsrc_pkg::hsrc_ctl_t ctl,
    input  wire hsrc_pkg::hsrc_in_t  item,
    output hsrc_pkg::hsrc_state_t    state_upd
);
    import hsrc_pkg::*;

    hsrc_state_t state_reg;
    hsrc_state_t state_next;
    logic [7:0]  lc;
    logic [3:0]  pos;
    logic [11:0] acc;

    // Lowercase copy of the character and the decimal accumulation.
    assign lc  = (item.ch inside {[CH_UP_A:CH_UP_Z]}) ? item.ch + CASE_DELTA : item.ch;
    assign pos = state_reg.char_count;
    assign acc = {4'd0, state_reg.group_value} * 12'd10 + {8'd0, item.ch[3:0]};

    // Fold one character into the parse state.
    always_comb begin
        state_upd = state_reg;

        // Dotted quad parse.
        if (item.ch inside {[CH_0:CH_9]}) begin
            if (acc > 12'd255) begin
                state_upd.quad_ok     = 1'b0;
                state_upd.group_value = 8'd0;
            end else begin
                state_upd.group_value = acc[7:0];
            end
            state_upd.group_has_digit = 1'b1;
        end else if (item.ch == CH_DOT) begin
            if (!state_reg.group_has_digit || state_reg.dot_count == 2'd3) begin
                state_upd.quad_ok = 1'b0;
            end else begin
                state_upd.octet_store[state_reg.dot_count] = state_reg.group_value;
                state_upd.dot_count = state_reg.dot_count + 2'd1;
            end
            state_upd.group_value     = 8'd0;
            state_upd.group_has_digit = 1'b0;
        end else begin
            state_upd.quad_ok = 1'b0;
        end

        // Exact text matches against "localhost" and "0.0.0.0".
        if (pos >= LH_LEN || lc != lh_char(pos)) begin
            state_upd.localhost_match = 1'b0;
        end
        if (pos >= ZQ_LEN || item.ch != zq_char(pos)) begin
            state_upd.zero_quad_match = 1'b0;
        end

        if (item.ch == CH_COLON) begin
            state_upd.colon_seen = 1'b1;
        end

        // IPv6 normalization: leading bracket, zone suffix, head capture.
        if (pos == 4'd0 && item.ch == CH_LBRACK) begin
            state_upd.open_bracket = 1'b1;
        end else if (!state_reg.percent_seen) begin
            if (item.ch == CH_PERCENT) begin
                state_upd.percent_seen = 1'b1;
            end else begin
                if (state_reg.norm_count < NORM_HEAD_LEN) begin
                    state_upd.norm_head[state_reg.norm_count[2:0]] = lc;
                end
                if (state_reg.norm_count != COUNT_MAX) begin
                    state_upd.norm_count = state_reg.norm_count + 4'd1;
                end
            end
        end

        state_upd.held_char = item.ch;
        if (state_reg.char_count != COUNT_MAX) begin
            state_upd.char_count = state_reg.char_count + 4'd1;
        end
    end

    // A finished or empty host returns the state to its reset values.
    always_comb begin
        state_next = state_reg;
        if (ctl.step) begin
            state_next = ctl.restart ? HSRC_STATE_RST : state_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HSRC_STATE_RST;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* sv/hsrc_classify.sv */
// ============================================================================
// Host string classifier decision
// Turns the parse state after the final character into the three result
// flags: IPv4 ranges, localhost, and the IPv6 reserved forms.
// ============================================================================
`default_nettype none

module hsrc_classify (
    input  wire hsrc_pkg::hsrc_state_t st,
    input  wire logic                  empty_host,
    output hsrc_pkg::hsrc_out_t        result
);
    import hsrc_pkg::*;

    logic       quad;
    logic       zero_quad;
    logic       v4_res;
    logic       v6_res;
    logic [3:0] n;
    logic [7:0] a, b, c;
    logic [7:0] h0, h1, h2;

    assign a  = st.octet_store[0];
    assign b  = st.octet_store[1];
    assign c  = st.octet_store[2];
    assign h0 = st.norm_head[0];
    assign h1 = st.norm_head[1];
    assign h2 = st.norm_head[2];

    assign quad      = st.quad_ok && st.dot_count == 2'd3 && st.group_has_digit;
    assign zero_quad = st.zero_quad_match && st.char_count == ZQ_LEN;

    // IPv4 private and reserved ranges.
    always_comb begin
        v4_res = 1'b0;
        if (a == 8'd10 || a == 8'd127 || a == 8'd0)              v4_res = 1'b1;
        if (a == 8'd169 && b == 8'd254)                          v4_res = 1'b1;
        if (a == 8'd172 && (b inside {[8'd16:8'd31]}))           v4_res = 1'b1;
        if (a == 8'd192 && b == 8'd168)                          v4_res = 1'b1;
        if (a == 8'd100 && (b inside {[8'd64:8'd127]}))          v4_res = 1'b1;
        if (a == 8'd192 && b == 8'd0 && c == 8'd2)               v4_res = 1'b1;
        if (a == 8'd198 && b == 8'd51 && c == 8'd100)            v4_res = 1'b1;
        if (a == 8'd203 && b == 8'd0 && c == 8'd113)             v4_res = 1'b1;
        if (a == 8'd198 && b == 8'd18)                           v4_res = 1'b1;
        if (a >= 8'd224)                                         v4_res = 1'b1;
    end

    // IPv6 reserved forms; a closing bracket is dropped from the length.
    always_comb begin
        n      = st.norm_count;
        v6_res = 1'b0;
        if (st.open_bracket && !st.percent_seen && n != 4'd0) begin
            n = n - 4'd1;
        end
        if (st.open_bracket && st.held_char != CH_RBRACK) begin
            v6_res = 1'b0;
        end else begin
            if (n == 4'd0) v6_res = 1'b1;
            if (n == 4'd2 && h0 == CH_COLON && h1 == CH_COLON) v6_res = 1'b1;
            if (n == 4'd3 && h0 == CH_COLON && h1 == CH_COLON && h2 == CH_1) v6_res = 1'b1;
            if (n >= 4'd2 && h0 == CH_F && (h1 == CH_C || h1 == CH_D || h1 == CH_F)) begin
                v6_res = 1'b1;
            end
            if (n >= 4'd3 && h0 == CH_F && h1 == CH_E && (h2 inside {CH_8, CH_9, CH_A, CH_B})) begin
                v6_res = 1'b1;
            end
            if (n >= NORM_HEAD_LEN && st.norm_head == DOC_PREFIX) v6_res = 1'b1;
        end
    end

    // Final flag selection.
    always_comb begin
        if (empty_host) begin
            result.reserved    = 1'b1;
            result.dotted_quad = 1'b0;
            result.valid_host  = 1'b0;
        end else begin
            result.dotted_quad = quad;
            result.valid_host  = !zero_quad;
            if (quad) begin
                result.reserved = v4_res;
            end else if (st.localhost_match && st.char_count == LH_LEN) begin
                result.reserved = 1'b1;
            end else if (zero_quad) begin
                result.reserved = 1'b1;
            end else if (st.colon_seen) begin
                result.reserved = v6_res;
            end else begin
                result.reserved = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* test/host_string_reserved_classifier_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Host string reserved-range classifier testbench
// Streams host names into the classifier one character per item and checks
// the three result flags against a behavioral predictor. Directed hosts cover
// the special forms; random hosts mix dotted quads, localhost variants, IPv6
// text with brackets and zones, long strings and raw byte noise, under random
// idling on both channels.
// ============================================================================

module host_string_reserved_classifier_tb;
    import hsrc_pkg::*;

    localparam int HOST_CHAR_GOAL = 1900;
    localparam int MAX_GAP        = 5;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [71:0] LH_TXT  = "localhost";
    localparam logic [55:0] ZQ_TXT  = "0.0.0.0";
    localparam logic [63:0] DOC_TXT = "2001:db8";
    localparam logic [7:0]  CH_LOW_Z = 8'h7A;

    // Ways a generated dotted quad can be broken.
    typedef enum int {
        FLAW_NONE,
        FLAW_BIG_GROUP,
        FLAW_EMPTY_GROUP,
        FLAW_EXTRA_GROUP,
        FLAW_SHORT,
        FLAW_TRAIL_DOT,
        FLAW_STRAY_CHAR
    } quad_flaw_t;

    // Predicts the flags of each host and checks the results in order.
    class host_flag_scoreboard;
        logic [3:0] n_chars;
        logic [7:0] prev_ch;
        logic       quad_good;
        logic [1:0] dots;
        logic [7:0] grp_val;
        logic       grp_digit;
        logic [7:0] octet [3];
        logic       lh_hit;
        logic       zq_hit;
        logic       saw_colon;
        logic       lead_bracket;
        logic       saw_pct;
        logic [3:0] v6_len;
        logic [7:0] v6_head [8];
        hsrc_out_t  flags_due [$];
        int         results_seen;
        int         mismatches;

        function new();
            restart_host();
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void restart_host();
            n_chars      = '0;
            prev_ch      = '0;
            quad_good    = 1'b1;
            dots         = '0;
            grp_val      = '0;
            grp_digit    = 1'b0;
            foreach (octet[i]) octet[i] = '0;
            lh_hit       = 1'b1;
            zq_hit       = 1'b1;
            saw_colon    = 1'b0;
            lead_bracket = 1'b0;
            saw_pct      = 1'b0;
            v6_len       = '0;
            foreach (v6_head[i]) v6_head[i] = '0;
        endfunction

        function int pending();
            return flags_due.size();
        endfunction

        // Queue the flags that the next result must carry.
        function void expect_flags(hsrc_out_t f);
            flags_due.insert(flags_due.size(), f);
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_DELTA : c;
        endfunction

        // Advance every parse track by one character.
        function void scan_char(logic [7:0] c);
            int          pos;
            logic [7:0]  lc;
            int unsigned acc;
            pos = int'(n_chars);
            lc  = fold_case(c);

            // Dotted quad groups and octets.
            if (c >= CH_0 && c <= CH_9) begin
                acc = grp_val * 10 + (c - CH_0);
                if (acc > 255) begin
                    quad_good = 1'b0;
                    acc = 0;
                end
                grp_val   = acc[7:0];
                grp_digit = 1'b1;
            end else if (c == CH_DOT) begin
                if (!grp_digit || dots == 2'd3) begin
                    quad_good = 1'b0;
                end else begin
                    octet[dots] = grp_val;
                    dots = dots + 2'd1;
                end
                grp_val   = '0;
                grp_digit = 1'b0;
            end else begin
                quad_good = 1'b0;
            end

            // Exact matches against the fixed names.
            if (pos < int'(LH_LEN)) begin
                if (lc != LH_TXT[(8 - pos) * 8 +: 8]) lh_hit = 1'b0;
            end else begin
                lh_hit = 1'b0;
            end
            if (pos < int'(ZQ_LEN)) begin
                if (c != ZQ_TXT[(6 - pos) * 8 +: 8]) zq_hit = 1'b0;
            end else begin
                zq_hit = 1'b0;
            end

            if (c == CH_COLON) saw_colon = 1'b1;

            // IPv6 text: a leading bracket is held apart, a zone is dropped.
            if (pos == 0 && c == CH_LBRACK) begin
                lead_bracket = 1'b1;
            end else if (!saw_pct) begin
                if (c == CH_PERCENT) begin
                    saw_pct = 1'b1;
                end else begin
                    if (v6_len < NORM_HEAD_LEN) v6_head[v6_len[2:0]] = lc;
                    if (v6_len < COUNT_MAX) v6_len = v6_len + 4'd1;
                end
            end

            prev_ch = c;
            if (n_chars < COUNT_MAX) n_chars = n_chars + 4'd1;
        endfunction

        function logic v4_in_reserved_range();
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] c;
            a = octet[0];
            b = octet[1];
            c = octet[2];
            return (a == 8'd10 || a == 8'd127 || a == 8'd0) ||
                   (a == 8'd169 && b == 8'd254) ||
                   (a == 8'd172 && b >= 8'd16 && b <= 8'd31) ||
                   (a == 8'd192 && b == 8'd168) ||
                   (a == 8'd100 && b >= 8'd64 && b <= 8'd127) ||
                   (a == 8'd192 && b == 8'd0 && c == 8'd2) ||
                   (a == 8'd198 && b == 8'd51 && c == 8'd100) ||
                   (a == 8'd203 && b == 8'd0 && c == 8'd113) ||
                   (a == 8'd198 && b == 8'd18) ||
                   (a >= 8'd224);
        endfunction

        function logic v6_in_reserved_form();
            int   n;
            logic doc;
            n = int'(v6_len);
            // A bracket counts only when closed; the close is then not text.
            if (lead_bracket) begin
                if (prev_ch != CH_RBRACK) return 1'b0;
                if (!saw_pct && n > 0) n--;
            end
            if (n == 0) return 1'b1;
            if (n == 2 && v6_head[0] == CH_COLON && v6_head[1] == CH_COLON) return 1'b1;
            if (n == 3 && v6_head[0] == CH_COLON && v6_head[1] == CH_COLON &&
                v6_head[2] == CH_1) return 1'b1;
            if (n >= 2 && v6_head[0] == CH_F &&
                (v6_head[1] == CH_C || v6_head[1] == CH_D || v6_head[1] == CH_F))
                return 1'b1;
            if (n >= 3 && v6_head[0] == CH_F && v6_head[1] == CH_E &&
                (v6_head[2] == CH_8 || v6_head[2] == CH_9 ||
                 v6_head[2] == CH_A || v6_head[2] == CH_B))
                return 1'b1;
            doc = (n >= 8);
            for (int i = 0; i < 8; i++) begin
                if (v6_head[i] != DOC_TXT[(7 - i) * 8 +: 8]) doc = 1'b0;
            end
            return doc;
        endfunction

        // Called for every accepted input item.
        function void note_item(hsrc_in_t item);
            hsrc_out_t flags;
            logic      zero_host;
            if (item.empty_host) begin
                flags.reserved    = 1'b1;
                flags.dotted_quad = 1'b0;
                flags.valid_host  = 1'b0;
                expect_flags(flags);
                restart_host();
                return;
            end
            scan_char(item.ch);
            if (!item.last) return;

            zero_host         = zq_hit && n_chars == ZQ_LEN;
            flags.dotted_quad = quad_good && dots == 2'd3 && grp_digit;
            flags.valid_host  = !zero_host;
            if (flags.dotted_quad)              flags.reserved = v4_in_reserved_range();
            else if (lh_hit && n_chars == LH_LEN) flags.reserved = 1'b1;
            else if (zero_host)                 flags.reserved = 1'b1;
            else if (saw_colon)                 flags.reserved = v6_in_reserved_form();
            else                                flags.reserved = 1'b0;
            expect_flags(flags);
            restart_host();
        endfunction

        // Called for every accepted result item.
        function void check_result(hsrc_out_t got);
            hsrc_out_t want;
            results_seen++;
            if (flags_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result %b with nothing pending", $realtime, got);
                return;
            end
            want = flags_due.pop_front();
            if (got.reserved !== want.reserved || got.dotted_quad !== want.dotted_quad ||
                got.valid_host !== want.valid_host) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"[%0t] result %0d: reserved %b/%b dotted_quad %b/%b ",
                              "valid_host %b/%b (exp/got)"},
                             $realtime, results_seen, want.reserved, got.reserved,
                             want.dotted_quad, got.dotted_quad, want.valid_host, got.valid_host);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    hsrc_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    hsrc_out_t m_data;

    host_flag_scoreboard flags_sb;
    logic [7:0] host_txt [$];
    int  hosts_sent;
    int  chars_sent;
    int  quiet_cycles;
    bit  sender_calm;
    bit  receiver_calm;

    host_string_reserved_classifier i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Observe both channels, feed the scoreboard and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) flags_sb.note_item(s_data);
            if (m_valid && m_ready) flags_sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Result side: random stalls with calm stretches between them.
    initial begin
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Present one item after a random gap and hold it until accepted.
    task automatic drive_item(hsrc_in_t item);
        int gap;
        if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_empty();
        hsrc_in_t item;
        item.ch         = 8'($urandom_range(0, 255));
        item.last       = 1'($urandom_range(0, 1));
        item.empty_host = 1'b1;
        drive_item(item);
        hosts_sent++;
    endtask

    // Append one character to the host under construction.
    function automatic void add_host_char(logic [7:0] c);
        host_txt = {host_txt, c};
    endfunction

    // Send the built host; a cut host stops early and is then discarded.
    task automatic send_host(bit cut);
        hsrc_in_t item;
        int       stop;
        if (host_txt.size() == 0) add_host_char(CH_COLON);
        stop = cut ? $urandom_range(1, host_txt.size()) : host_txt.size();
        for (int i = 0; i < stop; i++) begin
            item.ch         = host_txt[i];
            item.last       = !cut && (i == stop - 1);
            item.empty_host = 1'b0;
            drive_item(item);
        end
        host_txt.delete();
        if (cut) send_empty();
        else hosts_sent++;
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (flags_sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic void put_str(string s, bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= CH_A && c <= CH_LOW_Z && $urandom_range(0, 1))
                c = c - CASE_DELTA;
            add_host_char(c);
        end
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] odd_char();
        string pool;
        pool = "0123456789.:[]%lLoOcCaAhHsStTfFeEdDbB9x-/ ";
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void put_octet(int v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0) s = {"0", s};
        put_str(s, 1'b0);
    endfunction

    function automatic int pick_first_octet();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 10;
            2:       return 127;
            3:       return 169;
            4:       return 172;
            5:       return 192;
            6:       return 100;
            7:       return 198;
            8:       return 203;
            9:       return 224;
            10:      return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_second_octet();
        case ($urandom_range(0, 13))
            0:       return 254;
            1:       return 16;
            2:       return 31;
            3:       return 15;
            4:       return 32;
            5:       return 168;
            6:       return 64;
            7:       return 127;
            8:       return 63;
            9:       return 128;
            10:      return 0;
            11:      return 51;
            12:      return 18;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_third_octet();
        case ($urandom_range(0, 5))
            0:       return 2;
            1:       return 100;
            2:       return 113;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Dotted quad, well formed most of the time.
    function automatic void build_quad();
        int         vals [5];
        int         groups;
        int         bad;
        quad_flaw_t flaw;
        flaw    = ($urandom_range(0, 4) == 0) ?
                  quad_flaw_t'($urandom_range(int'(FLAW_BIG_GROUP), int'(FLAW_STRAY_CHAR))) :
                  FLAW_NONE;
        vals[0] = pick_first_octet();
        vals[1] = pick_second_octet();
        vals[2] = pick_third_octet();
        vals[3] = $urandom_range(0, 255);
        vals[4] = $urandom_range(0, 255);
        groups  = (flaw == FLAW_SHORT) ? 3 : (flaw == FLAW_EXTRA_GROUP) ? 5 : 4;
        bad     = $urandom_range(0, groups - 1);
        for (int g = 0; g < groups; g++) begin
            if (g > 0) add_host_char(CH_DOT);
            if (flaw == FLAW_EMPTY_GROUP && g == bad) continue;
            if (flaw == FLAW_BIG_GROUP && g == bad)
                put_str($sformatf("%0d", $urandom_range(256, 999)), 1'b0);
            else
                put_octet(vals[g]);
        end
        if (flaw == FLAW_TRAIL_DOT) add_host_char(CH_DOT);
        if (flaw == FLAW_STRAY_CHAR)
            host_txt.insert($urandom_range(0, host_txt.size()), odd_char());
    endfunction

    // Localhost in any case, the all-zero address, and near misses of both.
    function automatic void build_named();
        string lh;
        lh = "localhost";
        case ($urandom_range(0, 7))
            0, 1, 2: put_str(lh, 1'b1);
            3:       put_str(lh.substr(0, $urandom_range(0, 7)), 1'b1);
            4: begin
                put_str(lh, 1'b1);
                add_host_char(odd_char());
            end
            5: begin
                put_str(lh, 1'b1);
                host_txt[$urandom_range(0, 8)] = odd_char();
            end
            6:       put_str("0.0.0.0", 1'b0);
            default: begin
                case ($urandom_range(0, 5))
                    0:       put_str("00.0.0.0", 1'b0);
                    1:       put_str("0.0.0.00", 1'b0);
                    2:       put_str("0.0.0.0.", 1'b0);
                    3:       put_str("0.0.0.0:", 1'b0);
                    4:       put_str("0.0.0", 1'b0);
                    default: begin
                        put_str("0.0.0.0", 1'b0);
                        host_txt[$urandom_range(0, 6)] = odd_char();
                    end
                endcase
            end
        endcase
    endfunction

    function automatic string pick_v6_start();
        case ($urandom_range(0, 17))
            0:       return "";
            1:       return "::";
            2:       return "::1";
            3:       return "fc";
            4:       return "fd";
            5:       return "fe8";
            6:       return "fe9";
            7:       return "fea";
            8:       return "feb";
            9:       return "fec";
            10:      return "ff";
            11:      return "2001:db8";
            12:      return "2001:db9";
            13:      return "fe";
            14:      return "f";
            15:      return "::2";
            16:      return "1";
            default: return "2001:";
        endcase
    endfunction

    // IPv6 text with optional brackets, zone and random groups.
    function automatic void build_v6();
        bit opened;
        int groups;
        opened = $urandom_range(0, 1);
        if (opened) add_host_char(CH_LBRACK);
        put_str(pick_v6_start(), 1'b1);
        if ($urandom_range(0, 2) != 0) begin
            groups = $urandom_range(1, 4);
            for (int g = 0; g < groups; g++) begin
                add_host_char(CH_COLON);
                if ($urandom_range(0, 5) == 0) add_host_char(CH_COLON);
                repeat ($urandom_range(1, 4)) add_host_char(hex_char());
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            add_host_char(CH_PERCENT);
            if ($urandom_range(0, 1)) put_str("eth0", 1'b1);
            else repeat ($urandom_range(0, 3)) add_host_char(odd_char());
        end
        if (opened ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 9) == 0))
            add_host_char(CH_RBRACK);
    endfunction

    function automatic void build_noise(int min_len, int max_len);
        repeat ($urandom_range(min_len, max_len)) add_host_char(odd_char());
    endfunction

    // Hosts past the length where the counters saturate.
    function automatic void build_long();
        case ($urandom_range(0, 4))
            0:       put_str("0000000010.0.0.1", 1'b0);
            1: begin
                if ($urandom_range(0, 1)) add_host_char(CH_LBRACK);
                put_str("2001:db8:85a3:0000:0000:8a2e:0370:7334", 1'b1);
                if ($urandom_range(0, 1)) add_host_char(CH_RBRACK);
            end
            2:       put_str("localhostlocalhost", 1'b1);
            3:       build_noise(16, 40);
            default: begin
                put_str("[fe80::1%", 1'b1);
                build_noise(8, 20);
                add_host_char(CH_RBRACK);
            end
        endcase
    endfunction

    // Stimulus, drain and verdict.
    initial begin
        bit paused;
        flags_sb      = new();
        hosts_sent    = 0;
        chars_sent    = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        paused        = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed hosts: empty, all-zero address, localhost in mixed case,
        // bracketed loopback and an open bracket that is never closed.
        send_empty();
        put_str("0.0.0.0", 1'b0);
        send_host(1'b0);
        put_str("LOCALhost", 1'b0);
        send_host(1'b0);
        put_str("[::1]", 1'b0);
        send_host(1'b0);
        put_str("[fc:", 1'b0);
        send_host(1'b0);

        // Random hosts, mostly well formed.
        while (chars_sent < HOST_CHAR_GOAL) begin
            if (!paused && chars_sent >= HOST_CHAR_GOAL / 2) begin
                pause_until_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 19:   begin build_quad();  send_host(1'b0); end
                7, 8:                   begin build_named(); send_host(1'b0); end
                9, 10, 11, 12, 13, 14:  begin build_v6();    send_host(1'b0); end
                15:                     begin build_noise(1, 12); send_host(1'b0); end
                16:                     begin build_long();  send_host(1'b0); end
                17:                     send_empty();
                default: begin
                    if ($urandom_range(0, 1)) build_v6();
                    else build_quad();
                    send_host(1'b1);
                end
            endcase
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (flags_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d hosts in %0d items, %0d results checked, %0d mismatches.",
                 hosts_sent, chars_sent, flags_sb.results_seen, flags_sb.mismatches);
        if (flags_sb.mismatches == 0 && flags_sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/hsrc_pkg.sv
sv/hsrc_scan.sv
sv/hsrc_classify.sv
sv/host_string_reserved_classifier.sv
test/host_string_reserved_classifier_tb.sv
